// ===== sv/ps2_scancode_to_ascii_fifo_macros.svh =====
// ----------------------------------------------------------------------------
// ps2 scan code to ascii fifo: assertion macros
// concurrent checks clocked on clock and disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_TO_ASCII_FIFO_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_FIFO_MACROS_SVH

`ifndef SYNTHESIS

`define PS2A_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ps2a assertion failed");

`define PS2A_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ps2a assertion failed");

`else

`define PS2A_ASSERT(label, expr)

`define PS2A_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/ps2a_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2a_pkg
// types, scan codes and the german key table shared by the converter
// ----------------------------------------------------------------------------
`default_nettype none

package ps2a_pkg;

   localparam logic [7:0] CODE_BREAK  = 8'hF0;
   localparam logic [7:0] CODE_EXT    = 8'hE0;
   localparam logic [7:0] CODE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;
   localparam logic [7:0] CODE_UP     = 8'h75;
   localparam logic [7:0] CODE_LEFT   = 8'h6B;
   localparam logic [7:0] CODE_DOWN   = 8'h72;
   localparam logic [7:0] CODE_RIGHT  = 8'h74;
   localparam logic [7:0] CODE_ENTER  = 8'h5A;
   localparam logic [7:0] CODE_BKSP   = 8'h66;
   localparam logic [7:0] CODE_DEL    = 8'h71;
   localparam logic [7:0] CODE_SPACE  = 8'h29;

   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_KEEP,
      OP_ERROR,
      OP_PUSH,
      OP_POP
   } ps2a_op_type;

   typedef struct packed {
      logic req_type;
      logic [7:0] scan_code;
      logic line_error;
   } ps2a_req_type;

   typedef struct packed {
      logic [6:0] char_out;
      logic char_valid;
      logic [1:0] error_bits;
      logic cursor_up;
      logic cursor_down;
      logic cursor_left;
      logic cursor_right;
      logic shift_held;
      logic extended_seen;
   } ps2a_rsp_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
      logic shift;
      logic ext;
   } ps2a_flags_type;

   typedef struct packed {
      ps2a_op_type op;
      logic [6:0] ch;
      logic line_error;
      ps2a_flags_type flags;
   } ps2a_entry_type;

   // 0 means no character for this code
   function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
      logic [6:0] kc;
      case (code)
         CODE_ENTER: kc = 7'h0D;
         CODE_BKSP:  kc = 7'h08;
         CODE_DEL:   kc = 7'h7F;
         CODE_SPACE: kc = 7'h20;
         8'h41: kc = shifted ? 7'h3B : 7'h2C;
         8'h5B: kc = shifted ? 7'h2A : 7'h2B;
         8'h4A: kc = shifted ? 7'h5F : 7'h2D;
         8'h49: kc = shifted ? 7'h3A : 7'h2E;
         8'h1C: kc = shifted ? 7'h41 : 7'h61;
         8'h32: kc = shifted ? 7'h42 : 7'h62;
         8'h21: kc = shifted ? 7'h43 : 7'h63;
         8'h23: kc = shifted ? 7'h44 : 7'h64;
         8'h24: kc = shifted ? 7'h45 : 7'h65;
         8'h2B: kc = shifted ? 7'h46 : 7'h66;
         8'h34: kc = shifted ? 7'h47 : 7'h67;
         8'h33: kc = shifted ? 7'h48 : 7'h68;
         8'h43: kc = shifted ? 7'h49 : 7'h69;
         8'h3B: kc = shifted ? 7'h4A : 7'h6A;
         8'h42: kc = shifted ? 7'h4B : 7'h6B;
         8'h4B: kc = shifted ? 7'h4C : 7'h6C;
         8'h3A: kc = shifted ? 7'h4D : 7'h6D;
         8'h31: kc = shifted ? 7'h4E : 7'h6E;
         8'h44: kc = shifted ? 7'h4F : 7'h6F;
         8'h4D: kc = shifted ? 7'h50 : 7'h70;
         8'h15: kc = shifted ? 7'h51 : 7'h71;
         8'h2D: kc = shifted ? 7'h52 : 7'h72;
         8'h1B: kc = shifted ? 7'h53 : 7'h73;
         8'h2C: kc = shifted ? 7'h54 : 7'h74;
         8'h3C: kc = shifted ? 7'h55 : 7'h75;
         8'h2A: kc = shifted ? 7'h56 : 7'h76;
         8'h1D: kc = shifted ? 7'h57 : 7'h77;
         8'h22: kc = shifted ? 7'h58 : 7'h78;
         8'h35: kc = shifted ? 7'h5A : 7'h7A;
         8'h1A: kc = shifted ? 7'h59 : 7'h79;
         8'h45: kc = shifted ? 7'h3D : 7'h30;
         8'h16: kc = shifted ? 7'h21 : 7'h31;
         8'h1E: kc = shifted ? 7'h22 : 7'h32;
         8'h26: kc = 7'h33;
         8'h25: kc = shifted ? 7'h24 : 7'h34;
         8'h2E: kc = shifted ? 7'h25 : 7'h35;
         8'h36: kc = shifted ? 7'h26 : 7'h36;
         8'h3D: kc = shifted ? 7'h2F : 7'h37;
         8'h3E: kc = shifted ? 7'h28 : 7'h38;
         8'h46: kc = shifted ? 7'h29 : 7'h39;
         default: kc = 7'h00;
      endcase
      return kc;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ps2_scancode_to_ascii_fifo.sv =====
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_fifo
// ps/2 set 2 scan bytes to 7-bit ascii (german layout) with a character ring
// ----------------------------------------------------------------------------
// One transfer in and one transfer out per clock while rsp_stall is low:
// every request (scan byte or pop) gives exactly one response, through the
// queue and the output register. The front stage tracks the break, extended,
// shift and cursor flags and decodes the key; a two-entry queue separates it
// from the back stage, which owns the character ring (RING_DEPTH entries,
// RING_DEPTH-1 usable, one write or one read per cycle) and the output
// register. error_bits give the line error and ring overflow of the most
// recent scan byte that was not a prefix, shift or cursor code.
`default_nettype none

module ps2_scancode_to_ascii_fifo #(
   parameter int RING_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ps2a_pkg::ps2a_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ps2a_pkg::ps2a_rsp_type rsp_data
);
   import ps2a_pkg::*;

   logic           queue_full, push, pop, head_valid;
   ps2a_entry_type push_data, head_data;

   ps2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_data  (push_data)
   );

   ps2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   ps2a_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/ps2a_front.sv =====
// ----------------------------------------------------------------------------
// ps2a_front
// accepts requests, tracks prefix and key flags, classifies each transfer
// ----------------------------------------------------------------------------
`default_nettype none

module ps2a_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  ps2a_pkg::ps2a_req_type   req_data,
   input  logic                     queue_full,
   output logic                     req_stall,
   output logic                     push,
   output ps2a_pkg::ps2a_entry_type push_data
);
   import ps2a_pkg::*;

   logic       break_ff, break_in;
   logic       ext_ff, ext_in;
   logic       shift_ff, shift_in;
   logic [3:0] arrow_ff, arrow_in;
   logic       held;
   logic [6:0] ch;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign held      = !break_ff;

   always_comb begin
      break_in = break_ff;
      ext_in   = ext_ff;
      shift_in = shift_ff;
      arrow_in = arrow_ff;
      ch       = 7'h00;
      push_data.op = OP_POP;
      if (req_data.req_type == REQ_SCAN) begin
         push_data.op = OP_KEEP;
         break_in = 1'b0;
         case (req_data.scan_code)
            CODE_BREAK: break_in = 1'b1;
            CODE_EXT: ext_in = held;
            CODE_LSHIFT, CODE_RSHIFT: shift_in = held;
            CODE_UP: arrow_in[0] = held;
            CODE_DOWN: arrow_in[1] = held;
            CODE_LEFT: arrow_in[2] = held;
            CODE_RIGHT: arrow_in[3] = held;
            default: begin
               ch = held ? key_char(req_data.scan_code, shift_ff) : 7'h00;
               push_data.op = (ch != 7'h00) ? OP_PUSH : OP_ERROR;
            end
         endcase
      end
      push_data.ch          = ch;
      push_data.line_error  = req_data.line_error;
      push_data.flags.up    = arrow_in[0];
      push_data.flags.down  = arrow_in[1];
      push_data.flags.left  = arrow_in[2];
      push_data.flags.right = arrow_in[3];
      push_data.flags.shift = shift_in;
      push_data.flags.ext   = ext_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         break_ff <= 1'b0;
         ext_ff   <= 1'b0;
         shift_ff <= 1'b0;
         arrow_ff <= 4'h0;
      end else if (push) begin
         break_ff <= break_in;
         ext_ff   <= ext_in;
         shift_ff <= shift_in;
         arrow_ff <= arrow_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ps2a_queue.sv =====
// ----------------------------------------------------------------------------
// ps2a_queue
// two-entry queue between the classifier and the ring
// ----------------------------------------------------------------------------
`default_nettype none

module ps2a_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ps2a_pkg::ps2a_entry_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output ps2a_pkg::ps2a_entry_type head_data
);
   import ps2a_pkg::*;

   `include "ps2_scancode_to_ascii_fifo_macros.svh"

   ps2a_entry_type         q_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_idx_ff;
   logic [QUEUE_IDX_W-1:0] rd_idx_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = q_ff[rd_idx_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_idx_ff <= wr_idx_ff + 1'b1;
         end
         if (pop) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_idx_ff] <= push_data;
      end
   end

   `PS2A_ASSERT(a_queue_no_overrun, !(push && full))
   `PS2A_ASSERT(a_queue_no_underrun, !(pop && !head_valid))
   `PS2A_ASSERT(a_queue_count_range, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== sv/ps2a_back.sv =====
// ----------------------------------------------------------------------------
// ps2a_back
// character ring, error bits and the registered result
// ----------------------------------------------------------------------------
`default_nettype none

module ps2a_back #(
   parameter int RING_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  ps2a_pkg::ps2a_entry_type head_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ps2a_pkg::ps2a_rsp_type   rsp_data
);
   import ps2a_pkg::*;

   `include "ps2_scancode_to_ascii_fifo_macros.svh"

   localparam int PTR_W = $clog2(RING_DEPTH);

   logic [6:0]       char_ring_mem [RING_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W-1:0] wr_nxt, rd_nxt;
   logic [1:0]       last_error_ff, last_error_in;
   logic             rsp_valid_ff;
   logic [6:0]       char_out_ff;
   logic             char_valid_ff;
   ps2a_flags_type   flags_ff;
   logic             take, ring_full, ring_empty, ring_we, ring_re;

   assign take       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop        = take;
   assign wr_nxt     = (wr_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_nxt     = (rd_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign ring_full  = wr_nxt == rd_ptr_ff;
   assign ring_empty = wr_ptr_ff == rd_ptr_ff;

   always_comb begin
      last_error_in = last_error_ff;
      ring_we       = 1'b0;
      ring_re       = 1'b0;
      case (head_data.op)
         OP_PUSH: begin
            last_error_in = {ring_full, head_data.line_error};
            ring_we       = take && !ring_full;
         end
         OP_ERROR: last_error_in = {1'b0, head_data.line_error};
         OP_POP: ring_re = take && !ring_empty;
         default: last_error_in = last_error_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         last_error_ff <= 2'b00;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            last_error_ff <= last_error_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ring_we) begin
            wr_ptr_ff <= wr_nxt;
         end
         if (ring_re) begin
            rd_ptr_ff <= rd_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         char_ring_mem[wr_nxt] <= head_data.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_re) begin
         char_out_ff <= char_ring_mem[rd_nxt];
      end else if (take) begin
         char_out_ff <= 7'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_valid_ff <= ring_re;
         flags_ff      <= head_data.flags;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.char_out      = char_out_ff;
   assign rsp_data.char_valid    = char_valid_ff;
   assign rsp_data.error_bits    = last_error_ff;
   assign rsp_data.cursor_up     = flags_ff.up;
   assign rsp_data.cursor_down   = flags_ff.down;
   assign rsp_data.cursor_left   = flags_ff.left;
   assign rsp_data.cursor_right  = flags_ff.right;
   assign rsp_data.shift_held    = flags_ff.shift;
   assign rsp_data.extended_seen = flags_ff.ext;

   `PS2A_ASSERT_NEXT(a_overflow_flag, take && head_data.op == OP_PUSH && ring_full, last_error_ff[1])
   `PS2A_ASSERT_NEXT(a_empty_pop, take && head_data.op == OP_POP && ring_empty, !char_valid_ff && char_out_ff == 7'h00)
   `PS2A_ASSERT(a_popped_char_nonzero, !(rsp_valid_ff && char_valid_ff) || char_out_ff != 7'h00)

endmodule

`default_nettype wire
